>>> rtl/core/lbbc_pkg.sv
// Shared types and codes for the LRU buffer cache core.
package lbbc_pkg;
    localparam logic [1:0] FN_GET     = 2'd0;
    localparam logic [1:0] FN_WRITE   = 2'd1;
    localparam logic [1:0] FN_RELEASE = 2'd2;
    localparam logic [1:0] FN_DIRTY   = 2'd3;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_NO_FREE = 2'd1;
    localparam logic [1:0] ERR_UNREF   = 2'd2;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  device;
        logic [31:0] block_number;
        logic [4:0]  slot;
    } t_req;

    typedef struct packed {
        logic [4:0] entry;
        logic       hit;
        logic       disk_read;
        logic       disk_write;
        logic [1:0] error;
    } t_rsp;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;       // capture request, start at entry zero
        logic scan_step;  // examine current entry, advance
        logic apply;      // perform the update for the request
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic scan_last;  // current entry is the last one
        logic slot_ok;    // request slot is inside the pool
    } t_sts;
endpackage

>>> rtl/core/lbbc_if.sv
// Valid/ready channel interface carrying a payload.
interface lbbc_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/lbbc_ctrl.sv
// Request sequencer: accept, scan, apply, deliver.
module lbbc_ctrl import lbbc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_APPLY, S_OUT} t_state;
    t_state r_state;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    always_comb begin
        o_cmd.load      = (r_state == S_IDLE) && i_in_valid;
        o_cmd.scan_step = (r_state == S_SCAN);
        o_cmd.apply     = (r_state == S_APPLY);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE:  if (i_in_valid) r_state <= S_SCAN;
                S_SCAN:  if (i_sts.scan_last) r_state <= S_APPLY;
                S_APPLY: r_state <= S_OUT;
                S_OUT:   if (i_out_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_out_after_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.apply |=> o_out_valid) else $error("no result after apply");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready) else $error("accept while result pending");
    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid) else $error("result dropped");
endmodule

>>> rtl/core/lbbc_dp.sv
// Tag store, counts, marks, recency ranks and the sequential scan.
module lbbc_dp import lbbc_pkg::*; #(
    parameter int NUM_BUFFERS = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cmd i_cmd,
    input  t_req i_req,
    output t_sts o_sts,
    output t_rsp o_rsp
);
    localparam int IW = $clog2(NUM_BUFFERS);

    logic [7:0]    r_dev  [NUM_BUFFERS];
    logic [31:0]   r_blk  [NUM_BUFFERS];
    logic [7:0]    r_cnt  [NUM_BUFFERS];
    logic [IW-1:0] r_rank [NUM_BUFFERS];
    logic [NUM_BUFFERS-1:0] r_vld, r_drt;

    t_req          r_req;
    logic [IW-1:0] r_idx;
    logic          r_hit, r_free;
    logic [IW-1:0] r_hbest, r_fbest;
    logic [IW-1:0] r_hrank, r_frank;
    t_rsp          r_rsp;
    t_rsp          n_rsp;

    logic [IW-1:0] w_ri;
    logic          w_hm, w_fm, w_slot_ok;
    logic [IW-1:0] w_slot;
    logic [7:0]    w_scnt;
    logic [IW-1:0] w_srank;

    assign w_ri = r_rank[r_idx];
    assign w_hm = (r_dev[r_idx] == r_req.device) && (r_blk[r_idx] == r_req.block_number);
    assign w_fm = (r_cnt[r_idx] == 8'd0) && !r_drt[r_idx];
    assign w_slot_ok = ({27'd0, r_req.slot} < 32'(NUM_BUFFERS));
    assign w_slot = IW'(r_req.slot);
    assign w_scnt = r_cnt[w_slot];
    assign w_srank = r_rank[w_slot];
    assign o_sts.scan_last = (r_idx == IW'(NUM_BUFFERS - 1));
    assign o_sts.slot_ok = w_slot_ok;
    assign o_rsp = r_rsp;

    // Result of the captured request, from the scan outcome and the pool state.
    always_comb begin
        n_rsp = '0;
        if (r_req.func == FN_GET) begin
            if (r_hit) begin
                n_rsp.entry     = 5'(r_hbest);
                n_rsp.hit       = 1'b1;
                n_rsp.disk_read = !r_vld[r_hbest];
            end else if (r_free) begin
                n_rsp.entry     = 5'(r_fbest);
                n_rsp.disk_read = 1'b1;
            end else begin
                n_rsp.error = ERR_NO_FREE;
            end
        end else begin
            n_rsp.entry = r_req.slot;
            if (w_slot_ok && (r_req.func == FN_WRITE)) begin
                n_rsp.disk_write = 1'b1;
            end
            if (w_slot_ok && (r_req.func == FN_RELEASE) && (w_scnt == 8'd0)) begin
                n_rsp.error = ERR_UNREF;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
            r_idx <= '0;
            r_hit <= 1'b0;
            r_free <= 1'b0;
        end else if (i_cmd.scan_step) begin
            if (w_hm && (!r_hit || w_ri > r_hrank)) begin
                r_hit <= 1'b1; r_hbest <= r_idx; r_hrank <= w_ri;
            end
            if (w_fm && (!r_free || w_ri < r_frank)) begin
                r_free <= 1'b1; r_fbest <= r_idx; r_frank <= w_ri;
            end
            if (!o_sts.scan_last) r_idx <= r_idx + IW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_BUFFERS; i++) begin
                r_dev[i] <= '0; r_blk[i] <= '0; r_cnt[i] <= '0;
                r_rank[i] <= IW'(i);
            end
            r_vld <= '0;
            r_drt <= '0;
        end else if (i_cmd.apply) begin
            r_rsp <= n_rsp;
            if (r_req.func == FN_GET) begin
                if (r_hit) begin
                    if (r_cnt[r_hbest] != 8'hFF) r_cnt[r_hbest] <= r_cnt[r_hbest] + 8'd1;
                    if (!r_vld[r_hbest]) begin
                        r_vld[r_hbest] <= 1'b1; r_drt[r_hbest] <= 1'b0;
                    end
                end else if (r_free) begin
                    r_dev[r_fbest] <= r_req.device;
                    r_blk[r_fbest] <= r_req.block_number;
                    r_cnt[r_fbest] <= 8'd1;
                    r_vld[r_fbest] <= 1'b1;
                    r_drt[r_fbest] <= 1'b0;
                end
            end else begin
                if (w_slot_ok) begin
                    unique case (r_req.func)
                        FN_WRITE: begin
                            r_vld[w_slot] <= 1'b1; r_drt[w_slot] <= 1'b0;
                        end
                        FN_RELEASE: begin
                            if (w_scnt != 8'd0) begin
                                r_cnt[w_slot] <= w_scnt - 8'd1;
                                if (w_scnt == 8'd1) begin
                                    // Independent per-entry rank shift.
                                    for (int i = 0; i < NUM_BUFFERS; i++) begin
                                        if (IW'(i) == w_slot)
                                            r_rank[i] <= IW'(NUM_BUFFERS - 1);
                                        else if (r_rank[i] > w_srank)
                                            r_rank[i] <= r_rank[i] - IW'(1);
                                    end
                                end
                            end
                        end
                        FN_DIRTY: r_drt[w_slot] <= 1'b1;
                        default: ;
                    endcase
                end
            end
        end
    end
endmodule

>>> rtl/core/lru_block_buffer_cache_core.sv
// Top level of the LRU buffer cache core.
// Each request beat is handled alone: it is captured in idle, then the
// datapath examines one entry per cycle in index order while keeping the
// most recent tag match and the least recent free, clean entry, then the
// update is applied, then the result beat is held until taken, after which
// the block is back in idle. A new request beat is accepted only once the
// result of the last one has been taken. Disk transfers that are requested
// are treated as completed at once.
module lru_block_buffer_cache_core import lbbc_pkg::*; #(
    parameter int NUM_BUFFERS = 32
) (
    input logic i_clk,
    input logic i_rst_n,
    lbbc_if.sink   i_req,
    lbbc_if.source o_rsp
);
    t_cmd w_cmd;
    t_sts w_sts;
    t_req w_req;
    t_rsp w_rsp;

    assign w_req = i_req.data;
    assign o_rsp.data = w_rsp;

    lbbc_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_req.valid), .o_in_ready(i_req.ready),
        .o_out_valid(o_rsp.valid), .i_out_ready(o_rsp.ready),
        .i_sts(w_sts), .o_cmd(w_cmd)
    );

    lbbc_dp #(.NUM_BUFFERS(NUM_BUFFERS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd(w_cmd), .i_req(w_req), .o_sts(w_sts), .o_rsp(w_rsp)
    );
endmodule

>>> sim/tb_lru_block_buffer_cache_core.sv
// Testbench for the LRU buffer cache core: directed and random requests checked against a predictor.
module tb_lru_block_buffer_cache_core;
    import lbbc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NBUF = 32;
    localparam int CYCLE_LIMIT = 400000;

    logic i_clk;
    logic i_rst_n;

    lbbc_if #(.T(t_req)) req_ch ();
    lbbc_if #(.T(t_rsp)) rsp_ch ();

    lru_block_buffer_cache_core #(.NUM_BUFFERS(NBUF)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    // Shadow copy of the tag pool.
    logic [7:0]  sh_dev   [NBUF];
    logic [31:0] sh_blk   [NBUF];
    logic [7:0]  sh_refs  [NBUF];
    logic        sh_valid [NBUF];
    logic        sh_dirty [NBUF];
    int          sh_rank  [NBUF];

    t_rsp rsp_pending[$];
    int   err_count;
    int   send_idle_pct;
    int   recv_idle_pct;
    longint cycle_cnt;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Run is ended if it ever goes far past the slowest correct finish.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("tb_lru_block_buffer_cache_core: errors");
            $finish;
        end
    end

    function automatic void pool_reset();
        for (int i = 0; i < NBUF; i++) begin
            sh_dev[i] = '0;
            sh_blk[i] = '0;
            sh_refs[i] = '0;
            sh_valid[i] = 1'b0;
            sh_dirty[i] = 1'b0;
            sh_rank[i] = i;
        end
    endfunction

    // Works out the response of one request and updates the shadow pool.
    function automatic t_rsp pool_predict(t_req rq);
        t_rsp rs;
        bit   found;
        int   best;
        int   old_rank;
        rs = '0;
        found = 0;
        best = 0;
        if (rq.func == FN_GET) begin
            for (int i = 0; i < NBUF; i++) begin
                if (sh_dev[i] == rq.device && sh_blk[i] == rq.block_number &&
                    (!found || sh_rank[i] > sh_rank[best])) begin
                    best = i;
                    found = 1;
                end
            end
            if (found) begin
                if (sh_refs[best] != 8'd255) sh_refs[best] = sh_refs[best] + 8'd1;
                rs.entry = best[4:0];
                rs.hit = 1'b1;
                rs.disk_read = ~sh_valid[best];
                if (!sh_valid[best]) begin
                    sh_valid[best] = 1'b1;
                    sh_dirty[best] = 1'b0;
                end
                return rs;
            end
            for (int i = 0; i < NBUF; i++) begin
                if (sh_refs[i] == 0 && !sh_dirty[i] &&
                    (!found || sh_rank[i] < sh_rank[best])) begin
                    best = i;
                    found = 1;
                end
            end
            if (!found) begin
                rs.error = ERR_NO_FREE;
                return rs;
            end
            sh_dev[best] = rq.device;
            sh_blk[best] = rq.block_number;
            sh_refs[best] = 8'd1;
            sh_valid[best] = 1'b1;
            sh_dirty[best] = 1'b0;
            rs.entry = best[4:0];
            rs.disk_read = 1'b1;
            return rs;
        end
        rs.entry = rq.slot;
        if (int'(rq.slot) >= NBUF) return rs;
        case (rq.func)
            FN_WRITE: begin
                sh_valid[rq.slot] = 1'b1;
                sh_dirty[rq.slot] = 1'b0;
                rs.disk_write = 1'b1;
            end
            FN_RELEASE: begin
                if (sh_refs[rq.slot] == 0) begin
                    rs.error = ERR_UNREF;
                end else begin
                    sh_refs[rq.slot] = sh_refs[rq.slot] - 8'd1;
                    if (sh_refs[rq.slot] == 0) begin
                        // The released entry becomes the most recent one.
                        old_rank = sh_rank[rq.slot];
                        for (int i = 0; i < NBUF; i++)
                            if (sh_rank[i] > old_rank) sh_rank[i]--;
                        sh_rank[rq.slot] = NBUF - 1;
                    end
                end
            end
            default: sh_dirty[rq.slot] = 1'b1;
        endcase
        return rs;
    endfunction

    // Sends one request beat; the prediction is queued when it is accepted.
    // Called and returning at a falling edge.
    task automatic send_req(logic [1:0] fn, logic [7:0] dv, logic [31:0] bn,
                            logic [4:0] sl);
        t_req rq;
        rq.func = fn;
        rq.device = dv;
        rq.block_number = bn;
        rq.slot = sl;
        while ($urandom_range(99) < send_idle_pct) @(negedge i_clk);
        req_ch.valid = 1'b1;
        req_ch.data = rq;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        rsp_pending.push_back(pool_predict(rq));
        @(negedge i_clk);
        req_ch.valid = 1'b0;
    endtask

    // Receiver: random stalls, checks every response beat at the rising edge.
    always @(negedge i_clk) begin
        if (!i_rst_n) rsp_ch.ready <= 1'b0;
        else rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_rsp exp_rs;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (rsp_pending.size() == 0) begin
                $display("%0t: response beat with none expected: got %p", $time,
                         rsp_ch.data);
                err_count++;
            end else begin
                exp_rs = rsp_pending.pop_front();
                if (rsp_ch.data !== exp_rs) begin
                    $display("%0t: mismatch expected %p actual %p", $time, exp_rs,
                             rsp_ch.data);
                    err_count++;
                end
            end
        end
    end

    task automatic wait_drain();
        while (rsp_pending.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Corner cases: empty-pool tags, extreme fields, every function code,
    // saturation and the no-free-buffer error.
    task automatic test_directed();
        send_req(FN_RELEASE, 8'd0, 32'd0, 5'd0);          // release unreferenced
        send_req(FN_GET, 8'd0, 32'd0, 5'd0);              // hits never-loaded zero tag
        send_req(FN_GET, 8'hFF, 32'hFFFF_FFFF, 5'd31);    // miss, recycles oldest
        send_req(FN_GET, 8'hFF, 32'hFFFF_FFFF, 5'd0);     // hit
        send_req(FN_DIRTY, 8'd0, 32'd0, 5'd31);           // dirty, referenced
        send_req(FN_WRITE, 8'd0, 32'd0, 5'd31);
        send_req(FN_RELEASE, 8'd0, 32'd0, 5'd1);
        send_req(FN_RELEASE, 8'd0, 32'd0, 5'd1);
        send_req(FN_DIRTY, 8'hAA, 32'h5555_5555, 5'd1);
        send_req(FN_GET, 8'h55, 32'hAAAA_AAAA, 5'd0);
        // Saturate one count past 255.
        for (int i = 0; i < 260; i++) send_req(FN_GET, 8'h12, 32'd7, 5'($urandom));
        // Fill the pool so a further miss finds nothing free.
        for (int i = 0; i < NBUF + 1; i++) send_req(FN_GET, 8'h40, 32'(i + 100), 5'd0);
        wait_drain();
    endtask

    // Gets, mostly from a small tag set, mixed with releases, writes and dirty marks of random slots.
    task automatic test_random(int count);
        logic [1:0]  fn;
        logic [31:0] bn;
        int          pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            fn = pick < 45 ? FN_GET : pick < 80 ? FN_RELEASE :
                 pick < 90 ? FN_WRITE : FN_DIRTY;
            bn = ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(40));
            send_req(fn, ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(2)),
                     bn, 5'($urandom));
        end
        wait_drain();
    endtask

    initial begin
        err_count = 0;
        cycle_cnt = 0;
        send_idle_pct = 36;
        recv_idle_pct = 72;
        i_rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        rsp_ch.ready = 1'b0;
        pool_reset();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random(100);
        send_idle_pct = 72;
        recv_idle_pct = 36;
        test_random(100);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(150);
        repeat (3 * NBUF) @(posedge i_clk);
        if (err_count == 0) $display("tb_lru_block_buffer_cache_core: clean");
        else $display("tb_lru_block_buffer_cache_core: errors");
        $finish;
    end
endmodule
